// File: rtl/fcts_pkg.sv
`timescale 1ns / 1ps
// fcts_pkg: shared types and constants for the flow completion time stats block
// depends on nothing; imported by fcts_ram users, fcts_div and the top level
package fcts_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = AW + 1;

  // field widths
  localparam int SIZE_W = 31;
  localparam int TIME_W = 32;

  // group sum widths: one element per slot can be added without overflow
  localparam int SSUM_W = SIZE_W + AW;
  localparam int FSUM_W = TIME_W + AW;
  localparam int DIV_W  = FSUM_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  // register reset values
  localparam logic [SIZE_W-1:0] THRES_SMALL_RST = SIZE_W'(100 * 1000);
  localparam logic [SIZE_W-1:0] THRES_LARGE_RST = SIZE_W'(10 * 1000 * 1000);
  localparam logic [31:0]       SAT32           = 32'hffff_ffff;

  // register indexes
  localparam logic REG_THRES_SMALL = 1'b0;
  localparam logic REG_THRES_LARGE = 1'b1;

  // input kinds
  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_END    = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_REPORT = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // size groups
  localparam logic [1:0] GRP_SMALL = 2'd0;
  localparam logic [1:0] GRP_MID   = 2'd1;
  localparam logic [1:0] GRP_LARGE = 2'd2;

  // one table entry
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] fct;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // divider request
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/fcts_ram.sv
`timescale 1ns / 1ps
// fcts_ram: generic single write port, single read port ram with registered read
// depends on nothing
module fcts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fcts_div.sv
`timescale 1ns / 1ps
// fcts_div: restoring divider, one quotient bit per cycle
// depends on fcts_pkg
module fcts_div import fcts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [CNT_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [CNT_W-1:0]  divisor;
  logic [STEP_W-1:0] steps;
  logic              run;
  logic              done;

  logic [CNT_W:0]    shifted;
  logic              ge;
  logic [CNT_W:0]    diff;

  // one subtract and compare per step
  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run   <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (run) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (run) begin
      rem <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: rtl/flow_completion_time_stats.sv
`timescale 1ns / 1ps
// flow_completion_time_stats: flow table with per-group completion time report
// start, end, delete, error and unused kinds: the entry update and the result are made in
//   S_EXEC, and the result is offered in the state after it, S_OUT
// report: a walk over all TABLE_DEPTH slots, then per group one setup state and, for a
//   non-empty group, two divisions on the shared divider
// one transaction at a time; in_stall is high from acceptance until the last result goes
// reset clears control state, then a clearing pass over every slot empties the table
module flow_completion_time_stats import fcts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        kind,
  input  logic [9:0]        slot,
  input  logic [SIZE_W-1:0] flow_bytes,
  input  logic [TIME_W-1:0] time_us,
  input  logic              error_is_connection,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [1:0]        group,
  output logic [CNT_W-1:0]  flow_count,
  output logic [SIZE_W-1:0] avg_bytes,
  output logic [TIME_W-1:0] avg_fct,
  output logic [31:0]       size_errors,
  output logic [31:0]       connection_errors,
  output logic              last
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_DIVS  = 4'd4;
  localparam logic [3:0] S_WAITS = 4'd5;
  localparam logic [3:0] S_WAITF = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]        state;
  logic [CNT_W-1:0]  clear_addr;
  logic [CNT_W-1:0]  walk_addr;
  logic              rd_vld;
  logic [1:0]        grp;

  logic [SIZE_W-1:0] thres_small;
  logic [SIZE_W-1:0] thres_large;
  logic [31:0]       size_error_count;
  logic [31:0]       conn_error_count;

  logic [2:0]        kind_q;
  logic [9:0]        slot_q;
  logic [SIZE_W-1:0] size_q;
  logic [TIME_W-1:0] time_q;

  logic [CNT_W-1:0]  cnt  [3];
  logic [SSUM_W-1:0] ssum [3];
  logic [FSUM_W-1:0] fsum [3];

  logic              in_take;
  logic              out_take;
  logic              slot_range;
  logic [AW-1:0]     slot_addr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  slot_entry_t       ram_wentry;
  logic [AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  slot_entry_t       rd_entry;
  logic [1:0]        rd_grp;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign slot_addr = AW'(slot_q);
  assign slot_range = 32'(slot_q) >= 32'(TABLE_DEPTH);
  assign rd_entry  = slot_entry_t'(ram_rdata);

  assign size_errors       = size_error_count;
  assign connection_errors = conn_error_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thres_small <= THRES_SMALL_RST;
      thres_large <= THRES_LARGE_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_THRES_SMALL) begin
        thres_small <= cfg_data;
      end else begin
        thres_large <= cfg_data;
      end
    end
  end

  // read address: walk counter during a report, else the incoming slot
  always_comb begin
    if (state == S_WALK) begin
      ram_raddr = walk_addr[AW-1:0];
    end else begin
      ram_raddr = AW'(slot);
    end
  end

  // size group of the entry read back
  always_comb begin
    if (rd_entry.size < thres_small) begin
      rd_grp = GRP_SMALL;
    end else if (rd_entry.size < thres_large) begin
      rd_grp = GRP_MID;
    end else begin
      rd_grp = GRP_LARGE;
    end
  end

  // table write: clearing pass or the entry update of one transaction
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = slot_addr;
    ram_wentry = rd_entry;
    if (state == S_CLEAR) begin
      ram_we     = 1'b1;
      ram_waddr  = clear_addr[AW-1:0];
      ram_wentry = '0;
    end else if (state == S_EXEC && !slot_range) begin
      case (kind_q)
        KIND_START: begin
          ram_we                = !rd_entry.valid;
          ram_wentry.valid      = 1'b1;
          ram_wentry.size       = size_q;
          ram_wentry.start_time = time_q;
          ram_wentry.fct        = '0;
        end
        KIND_END: begin
          ram_we         = rd_entry.valid;
          ram_wentry.fct = time_q - rd_entry.start_time;
        end
        KIND_DELETE: begin
          ram_we           = 1'b1;
          ram_wentry.valid = 1'b0;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  fcts_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ENTRY_W'(ram_wentry)),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // divider requests: size sum first, then completion time sum
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(ssum[grp]);
    div_req.divisor  = cnt[grp];
    if (state == S_DIVS && cnt[grp] != '0) begin
      div_req.start = 1'b1;
    end else if (state == S_WAITS && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = fsum[grp];
    end
  end

  fcts_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clear_addr       <= '0;
      out_valid        <= 1'b0;
      size_error_count <= '0;
      conn_error_count <= '0;
      walk_addr        <= '0;
      rd_vld           <= 1'b0;
      grp              <= GRP_SMALL;
    end else begin
      case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == CNT_W'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            if (kind == KIND_REPORT) begin
              state     <= S_WALK;
              walk_addr <= '0;
              rd_vld    <= 1'b0;
              grp       <= GRP_SMALL;
            end else begin
              state <= S_EXEC;
            end
            if (kind == KIND_ERROR) begin
              if (error_is_connection) begin
                if (conn_error_count != SAT32) begin
                  conn_error_count <= conn_error_count + 1'b1;
                end
              end else if (size_error_count != SAT32) begin
                size_error_count <= size_error_count + 1'b1;
              end
            end
          end
        end
        S_EXEC: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_WALK: begin
          rd_vld <= (walk_addr != CNT_W'(TABLE_DEPTH));
          if (walk_addr != CNT_W'(TABLE_DEPTH)) begin
            walk_addr <= walk_addr + 1'b1;
          end else if (!rd_vld) begin
            state <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (cnt[grp] == '0) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_WAITS;
          end
        end
        S_WAITS: begin
          if (div_rsp.done) begin
            state <= S_WAITF;
          end
        end
        S_WAITF: begin
          if (div_rsp.done) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_take) begin
            out_valid <= 1'b0;
            if (kind_q == KIND_REPORT && grp != GRP_LARGE) begin
              grp   <= grp + 1'b1;
              state <= S_DIVS;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // captured transaction fields
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_q <= kind;
      slot_q <= slot;
      size_q <= flow_bytes;
      time_q <= time_us;
    end
  end

  // group accumulators, rebuilt on every report
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      for (int g = 0; g < 3; g++) begin
        cnt[g]  <= '0;
        ssum[g] <= '0;
        fsum[g] <= '0;
      end
    end else if (state == S_WALK && rd_vld && rd_entry.valid) begin
      cnt[rd_grp]  <= cnt[rd_grp] + 1'b1;
      ssum[rd_grp] <= ssum[rd_grp] + SSUM_W'(rd_entry.size);
      fsum[rd_grp] <= fsum[rd_grp] + FSUM_W'(rd_entry.fct);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      group      <= GRP_SMALL;
      flow_count <= '0;
      avg_bytes  <= '0;
      avg_fct    <= '0;
      last       <= 1'b1;
      status     <= ST_OK;
      if (kind_q inside {KIND_START, KIND_END, KIND_DELETE}) begin
        if (slot_range) begin
          status <= ST_RANGE;
        end else if (kind_q == KIND_START && rd_entry.valid) begin
          status <= ST_BUSY;
        end else if (kind_q == KIND_END && !rd_entry.valid) begin
          status <= ST_EMPTY;
        end
      end
    end else if (state == S_DIVS) begin
      status     <= ST_OK;
      group      <= grp;
      flow_count <= cnt[grp];
      avg_bytes  <= '0;
      avg_fct    <= '0;
      last       <= (grp == GRP_LARGE);
    end else if (state == S_WAITS && div_rsp.done) begin
      avg_bytes <= div_rsp.quotient[SIZE_W-1:0];
    end else if (state == S_WAITF && div_rsp.done) begin
      avg_fct <= div_rsp.quotient[TIME_W-1:0];
    end
  end

endmodule
